### src/gdad_pkg.sv
package gdad_pkg;

   localparam int unsigned MaxYear = 9999;
   localparam int unsigned DaysPer400y = 146097;
   localparam int unsigned DaysPer100y = 36524;
   localparam int unsigned DaysPer4y = 1461;
   localparam int unsigned DaysPerYear = 365;

   // day number of MaxYear-12-31
   localparam int unsigned LastDay = (MaxYear - 1) * 365 + (MaxYear - 1) / 4
                                     - (MaxYear - 1) / 100 + (MaxYear - 1) / 400 + 364;

   // reciprocals for the constant divisions, exact over the ranges in use
   localparam int unsigned Recip100 = ((1 << 19) + 99) / 100;
   localparam longint unsigned Recip400y = ((64'd1 << 40) + 64'(DaysPer400y) - 64'd1)
                                           / 64'(DaysPer400y);
   localparam longint unsigned Recip4y = ((64'd1 << 28) + 64'(DaysPer4y) - 64'd1)
                                         / 64'(DaysPer4y);

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_DATE  = 2'd1;
   localparam logic [1:0] STATUS_OUT_RANGE = 2'd2;

   typedef struct packed {
      logic [4:0]  result_day;
      logic [3:0]  result_month;
      logic [13:0] result_year;
      logic [1:0]  status;
   } result_type;

   function automatic logic is_leap(input logic [13:0] y);
      logic [26:0] p;
      logic [7:0]  c;
      logic        cent;
      // c is y / 100
      p = 27'(y) * 27'(Recip100);
      c = p[26:19];
      cent = (y == 14'(c) * 14'd100);
      return (y[1:0] == 2'd0) && (!cent || c[1:0] == 2'd0);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] n;
      unique case (m)
         4'd2: n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

   // days before the first of month m
   function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
      logic [8:0] n;
      unique case (m)
         4'd1: n = 9'd0;
         4'd2: n = 9'd31;
         4'd3: n = 9'd59;
         4'd4: n = 9'd90;
         4'd5: n = 9'd120;
         4'd6: n = 9'd151;
         4'd7: n = 9'd181;
         4'd8: n = 9'd212;
         4'd9: n = 9'd243;
         4'd10: n = 9'd273;
         4'd11: n = 9'd304;
         default: n = 9'd334;
      endcase
      if (leap && m > 4'd2) begin
         n = n + 9'd1;
      end
      return n;
   endfunction

endpackage

### src/gdad_to_daynum.sv
module gdad_to_daynum (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [4:0]         day_of_month,
   input  logic [3:0]         month_number,
   input  logic [13:0]        year_number,
   input  logic signed [22:0] day_offset,
   output logic               out_valid,
   output logic               out_bad,
   output logic signed [24:0] out_sum
);

   // stage 1: check and split the year
   logic        v1_ff, v1_in;
   logic        bad1_ff, bad1_in;
   logic [13:0] yy1_ff, yy1_in;
   logic [7:0]  cent1_ff, cent1_in;
   logic [8:0]  doy1_ff, doy1_in;
   logic signed [22:0] off1_ff;
   // stage 2: day number plus offset
   logic        v2_ff;
   logic        bad2_ff;
   logic signed [24:0] sum2_ff, sum2_in;
   logic        leap;
   logic [26:0] cprod;
   logic [21:0] yearpart;

   always_comb begin
      leap = gdad_pkg::is_leap(year_number);
      bad1_in = (year_number == 14'd0) || (year_number > 14'(gdad_pkg::MaxYear))
                || (month_number == 4'd0) || (month_number > 4'd12)
                || (day_of_month == 5'd0)
                || (day_of_month > gdad_pkg::month_days(month_number, leap));
      yy1_in = year_number - 14'd1;
      // whole centuries in yy
      cprod = 27'(yy1_in) * 27'(gdad_pkg::Recip100);
      cent1_in = cprod[26:19];
      doy1_in = gdad_pkg::days_before(month_number, leap) + 9'(day_of_month) - 9'd1;
      v1_in = in_valid;
      yearpart = 22'(yy1_ff) * 22'd365 + 22'(yy1_ff >> 2) - 22'(cent1_ff)
                 + 22'(cent1_ff >> 2);
      sum2_in = 25'(signed'({3'b000, yearpart})) + 25'(signed'({1'b0, doy1_ff}))
                + 25'(off1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         bad1_ff <= bad1_in;
         yy1_ff <= yy1_in;
         cent1_ff <= cent1_in;
         doy1_ff <= doy1_in;
         off1_ff <= day_offset;
         bad2_ff <= bad1_ff;
         sum2_ff <= sum2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_bad = bad2_ff;
   assign out_sum = sum2_ff;

endmodule

### src/gdad_from_daynum.sv
module gdad_from_daynum (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic               in_bad,
   input  logic signed [24:0] in_sum,
   output logic               out_valid,
   output gdad_pkg::result_type out_result
);

   // stage 3: range check, 400-year split
   logic        v3_ff;
   logic [1:0]  st3_ff, st3_in;
   logic [4:0]  q400_3_ff, q400_3_in;
   logic [17:0] r3_ff, r3_in;
   // stage 4: century and 4-year split
   logic        v4_ff;
   logic [1:0]  st4_ff;
   logic [13:0] ybase4_ff, ybase4_in;
   logic [10:0] r4_ff, r4_in;
   logic        cent4_ff, cent4_in;
   // stage 5: year and month
   logic        v5_ff;
   gdad_pkg::result_type res5_ff, res5_in;

   logic [21:0] n;
   logic [44:0] p400;
   logic [34:0] p4;
   logic [1:0]  q100, q1;
   logic [16:0] r100;
   logic [5:0]  q4;
   logic [8:0]  doy;
   logic [13:0] yr;
   logic        lp;
   logic [3:0]  mm;

   always_comb begin
      n = in_sum[21:0];
      if (in_bad) begin
         st3_in = gdad_pkg::STATUS_BAD_DATE;
      end else if (in_sum < 25'sd0 || in_sum > 25'(gdad_pkg::LastDay)) begin
         st3_in = gdad_pkg::STATUS_OUT_RANGE;
      end else begin
         st3_in = gdad_pkg::STATUS_OK;
      end
      p400 = 45'(n) * 45'(gdad_pkg::Recip400y);
      q400_3_in = 5'(p400 >> 40);
      r3_in = 18'(n - 22'(q400_3_in) * 22'(gdad_pkg::DaysPer400y));

      if (r3_ff >= 18'(3 * gdad_pkg::DaysPer100y)) q100 = 2'd3;
      else if (r3_ff >= 18'(2 * gdad_pkg::DaysPer100y)) q100 = 2'd2;
      else if (r3_ff >= 18'(gdad_pkg::DaysPer100y)) q100 = 2'd1;
      else q100 = 2'd0;
      r100 = 17'(r3_ff - 18'(q100) * 18'(gdad_pkg::DaysPer100y));
      p4 = 35'(r100) * 35'(gdad_pkg::Recip4y);
      q4 = 6'(p4 >> 28);
      r4_in = 11'(r100 - 17'(q4) * 17'(gdad_pkg::DaysPer4y));
      ybase4_in = 14'(q400_3_ff) * 14'd400 + 14'(q100) * 14'd100 + 14'(q4) * 14'd4;
      // last year of this 4-year block is a century that is not a leap year
      cent4_in = (q4 == 6'd24) && (q100 != 2'd3);

      if (r4_ff >= 11'(3 * gdad_pkg::DaysPerYear)) q1 = 2'd3;
      else if (r4_ff >= 11'(2 * gdad_pkg::DaysPerYear)) q1 = 2'd2;
      else if (r4_ff >= 11'(gdad_pkg::DaysPerYear)) q1 = 2'd1;
      else q1 = 2'd0;
      doy = 9'(r4_ff - 11'(q1) * 11'(gdad_pkg::DaysPerYear));
      yr = ybase4_ff + 14'(q1) + 14'd1;
      lp = (q1 == 2'd3) && !cent4_ff;
      mm = 4'd1;
      for (int i = 2; i <= 12; i++) begin
         if (doy >= gdad_pkg::days_before(4'(i), lp)) mm = 4'(i);
      end
      res5_in.status = st4_ff;
      if (st4_ff == gdad_pkg::STATUS_OK) begin
         res5_in.result_year = yr;
         res5_in.result_month = mm;
         res5_in.result_day = 5'(doy - gdad_pkg::days_before(mm, lp) + 9'd1);
      end else begin
         res5_in.result_year = '0;
         res5_in.result_month = '0;
         res5_in.result_day = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (advance) begin
         st3_ff <= st3_in;
         q400_3_ff <= q400_3_in;
         r3_ff <= r3_in;
         st4_ff <= st3_ff;
         ybase4_ff <= ybase4_in;
         r4_ff <= r4_in;
         cent4_ff <= cent4_in;
         res5_ff <= res5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_result = res5_ff;

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      v5_ff && res5_ff.status == gdad_pkg::STATUS_OK |->
         res5_ff.result_month >= 4'd1 && res5_ff.result_month <= 4'd12
         && res5_ff.result_day >= 5'd1)
      else $error("ok result with bad month or day");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      v5_ff && res5_ff.status != gdad_pkg::STATUS_OK |->
         res5_ff.result_year == 14'd0 && res5_ff.result_day == 5'd0)
      else $error("error result with nonzero date");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(v5_ff) && $stable(res5_ff))
      else $error("stage 5 moved while stalled");

endmodule

### src/gregorian_date_add_days_core.sv
// channel | dir | tdata fields, lowest bit first
// req_    | in  | day_of_month[4:0] month_number[8:5] year_number[22:9] day_offset[45:23]
// rsp_    | out | result_day[4:0] result_month[8:5] result_year[22:9] status[24:23]
// five register stages, one item enters per cycle unless a stall on rsp_tready holds it
// the whole pipeline and output register advance together when the output is free
// a stall on rsp_tready holds every stage, nothing lost or repeated
// reset clears the valid bits only
module gregorian_date_add_days_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // day_of_month, month_number, year_number, day_offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // result_day, result_month, result_year, status
);

   logic               advance;
   logic               mid_valid;
   logic               mid_bad;
   logic signed [24:0] mid_sum;
   gdad_pkg::result_type res;

   assign advance = rsp_tready || !rsp_tvalid;
   assign req_tready = advance;

   gdad_to_daynum u_to (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_tvalid),
      .day_of_month (req_tdata[4:0]),
      .month_number (req_tdata[8:5]),
      .year_number  (req_tdata[22:9]),
      .day_offset   (req_tdata[45:23]),
      .out_valid    (mid_valid),
      .out_bad      (mid_bad),
      .out_sum      (mid_sum)
   );

   gdad_from_daynum u_from (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (mid_valid),
      .in_bad     (mid_bad),
      .in_sum     (mid_sum),
      .out_valid  (rsp_tvalid),
      .out_result (res)
   );

   assign rsp_tdata = {7'd0, res.status, res.result_year, res.result_month, res.result_day};

endmodule

### sim/gregorian_date_add_days_core_tb.sv
`timescale 1ns / 100ps

module gregorian_date_add_days_core_tb;

   typedef struct {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [1:0]  status;
   } date_result_type;

   function automatic bit leap_year(longint y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return (y % 4) == 0;
   endfunction

   function automatic int unsigned month_length(longint m, longint y);
      int unsigned len;
      case (m)
         2: len = leap_year(y) ? 29 : 28;
         4, 6, 9, 11: len = 30;
         default: len = 31;
      endcase
      return len;
   endfunction

   function automatic longint date_to_daynum(longint d, longint m, longint y);
      longint yy;
      longint n;
      yy = y - 1;
      n = yy * 365 + yy / 4 - yy / 100 + yy / 400;
      for (longint i = 1; i < m; i++) n += longint'(month_length(i, y));
      return n + d - 1;
   endfunction

   function automatic date_result_type shifted_date(logic [4:0] d, logic [3:0] m,
                                                    logic [13:0] y, logic signed [22:0] off);
      date_result_type r;
      longint dd;
      longint mi;
      longint yi;
      longint n;
      longint rem;
      longint q100;
      longint q1;
      longint yr;
      longint mm;
      r = '{default: '0};
      dd = longint'(d);
      mi = longint'(m);
      yi = longint'(y);
      if (yi < 1 || yi > longint'(gdad_pkg::MaxYear) || mi < 1 || mi > 12 || dd < 1
          || dd > longint'(month_length(mi, yi))) begin
         r.status = gdad_pkg::STATUS_BAD_DATE;
         return r;
      end
      n = date_to_daynum(dd, mi, yi) + longint'(off);
      if (n < 0 || n > date_to_daynum(31, 12, longint'(gdad_pkg::MaxYear))) begin
         r.status = gdad_pkg::STATUS_OUT_RANGE;
         return r;
      end
      yr = (n / 146097) * 400;
      rem = n % 146097;
      q100 = rem / 36524;
      if (q100 > 3) q100 = 3;
      rem -= q100 * 36524;
      yr += q100 * 100 + (rem / 1461) * 4;
      rem = rem % 1461;
      q1 = rem / 365;
      if (q1 > 3) q1 = 3;
      rem -= q1 * 365;
      yr += q1 + 1;
      mm = 1;
      while (mm < 12 && rem >= longint'(month_length(mm, yr))) begin
         rem -= longint'(month_length(mm, yr));
         mm++;
      end
      r.day = 5'(rem + 1);
      r.month = 4'(mm);
      r.year = 14'(yr);
      r.status = gdad_pkg::STATUS_OK;
      return r;
   endfunction

   class date_scoreboard;
      date_result_type pending[$];
      int errors = 0;

      function void note_request(logic [45:0] data);
         pending.push_back(shifted_date(data[4:0], data[8:5], data[22:9], data[45:23]));
      endfunction

      function void check_response(logic [31:0] data);
         date_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected item %h", data);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[4:0] !== e.day) begin
            $error("result_day expected %0d actual %0d", e.day, data[4:0]);
            errors++;
         end
         if (data[8:5] !== e.month) begin
            $error("result_month expected %0d actual %0d", e.month, data[8:5]);
            errors++;
         end
         if (data[22:9] !== e.year) begin
            $error("result_year expected %0d actual %0d", e.year, data[22:9]);
            errors++;
         end
         if (data[24:23] !== e.status) begin
            $error("status expected %0d actual %0d", e.status, data[24:23]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   bit sending_done = 1'b0;

   date_scoreboard board = new();

   gregorian_date_add_days_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tdata[45:0]);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      end
   end

   function automatic int gap_length();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   task automatic send_date(int unsigned d, int unsigned m, int unsigned y, int signed off);
      int gap;
      gap = gap_length();
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {2'b00, off[22:0], y[13:0], m[3:0], d[4:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random_item();
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int signed off;
      int unsigned kind;
      kind = $urandom_range(0, 19);
      y = $urandom_range(1, gdad_pkg::MaxYear);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, month_length(longint'(m), longint'(y)));
      case ($urandom_range(0, 3))
         0: off = $signed($urandom_range(0, 800)) - 400;
         1: off = $signed($urandom_range(0, 80000)) - 40000;
         default: off = $signed($urandom_range(0, 7304116)) - 3652058;
      endcase
      if (kind == 0) begin
         d = $urandom_range(0, 31);
         m = $urandom_range(0, 15);
         y = $urandom_range(0, 16383);
      end else if (kind == 1) begin
         off = $signed($urandom) >>> 9;
      end else if (kind == 2) begin
         m = 2;
         y = $urandom_range(1, 2499) * 4;
         d = $urandom_range(28, 29);
      end
      send_date(d, m, y, off);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_date(1, 1, 1, 0);
      send_date(1, 1, 1, -1);
      send_date(31, 12, 9999, 0);
      send_date(31, 12, 9999, 1);
      send_date(1, 1, 1, 3652058);
      send_date(31, 12, 9999, -3652058);
      send_date(1, 1, 1, 3652059);
      send_date(31, 12, 9999, -4194304);
      send_date(1, 1, 1, 4194303);
      send_date(29, 2, 2000, 0);
      send_date(29, 2, 1900, 0);
      send_date(29, 2, 2024, 365);
      send_date(28, 2, 2100, 1);
      send_date(31, 12, 2000, 1);
      send_date(31, 4, 2021, 0);
      send_date(0, 5, 2021, 0);
      send_date(5, 0, 2021, 0);
      send_date(5, 13, 2021, 0);
      send_date(5, 5, 0, 0);
      send_date(5, 5, 10000, 0);
      send_date(31, 15, 16383, -1);
      send_date(1, 3, 2000, -1);
      req_tvalid <= 1'b0;
      wait (board.pending.size() == 0);
      @(negedge clock);
      for (int i = 0; i < 1650; i++) begin
         send_random_item();
         if (i == 800) begin
            req_tvalid <= 1'b0;
            wait (board.pending.size() == 0);
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_length() + 1) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   end

   initial begin
      wait (sending_done);
      wait (board.pending.size() == 0);
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
